>>> rtl/core/cme_pkg.sv
`default_nettype none

package cme_pkg;

   localparam int unsigned MAX_WIDTH_DEF  = 2048;
   localparam int unsigned MAX_HEIGHT_DEF = 2048;

   localparam int unsigned PIX_W      = 16;
   localparam int unsigned MIX_W      = 13;
   localparam int unsigned OUT_W      = 15;
   localparam int unsigned SIZE_W     = 12;
   localparam int unsigned TAP_W      = 16;
   localparam int unsigned NUM_TAPS   = 9;
   localparam int unsigned NUM_CH     = 3;
   localparam int unsigned CSR_DATA_W = 64;
   localparam int unsigned CSR_ADDR_W = 6;

   // Q1.12 unity for the mix factor
   localparam logic [MIX_W-1:0] MIX_ONE = 13'd4096;

   typedef enum logic [2:0] {
      REG_IMAGE_WIDTH  = 3'd0,
      REG_IMAGE_HEIGHT = 3'd1,
      REG_TAPS_LOW     = 3'd2,
      REG_TAPS_HIGH    = 3'd3,
      REG_TAP_LAST     = 3'd4
   } csr_index_type;

   typedef enum logic {
      CMD_PIXEL = 1'b0,
      CMD_DRAIN = 1'b1
   } command_type;

   typedef logic [PIX_W-1:0] pixel_type;

   // rgb[row][channel], row 0 top, channel 0 red
   typedef struct packed {
      pixel_type [2:0][2:0] rgb;
      pixel_type            alpha;
      logic [MIX_W-1:0]     mix;
   } column_type;

   typedef column_type [2:0] window_type;

   typedef struct packed {
      pixel_type [3:0]  c;
      logic [MIX_W-1:0] mix;
   } prev_entry_type;

   typedef pixel_type [2:0] older_entry_type;

   typedef logic [NUM_TAPS-1:0][TAP_W-1:0] tap_set_type;

   typedef logic [NUM_CH-1:0][OUT_W-1:0] rgb_out_type;

   typedef struct packed {
      logic rd_en;
      logic wr_prev;
      logic wr_older;
   } store_ctl_type;

   typedef enum logic [2:0] {
      EU_IDLE,
      EU_MAC,
      EU_ROUND,
      EU_SQUARE,
      EU_SQRT,
      EU_MIX,
      EU_SUM
   } eu_state_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_DISPATCH,
      CS_GATHER,
      CS_EMIT_START,
      CS_EMIT_WAIT,
      CS_EMIT_PUSH,
      CS_FINISH
   } core_state_type;

endpackage

`default_nettype wire

>>> rtl/core/cme_if.sv
`default_nettype none

interface cme_req_if;
   logic                     valid;
   logic                     ready;
   logic                     command;
   logic signed [15:0]       in_red;
   logic signed [15:0]       in_green;
   logic signed [15:0]       in_blue;
   logic signed [15:0]       in_alpha;
   logic [12:0]              mix_factor;

   modport source (output valid, command, in_red, in_green, in_blue, in_alpha, mix_factor,
                   input ready);
   modport sink   (input valid, command, in_red, in_green, in_blue, in_alpha, mix_factor,
                   output ready);
endinterface

interface cme_rsp_if;
   logic        valid;
   logic        ready;
   logic [14:0] out_red;
   logic [14:0] out_green;
   logic [14:0] out_blue;
   logic [14:0] out_alpha;
   logic        last_of_run;
   logic        end_of_frame;

   modport source (output valid, out_red, out_green, out_blue, out_alpha, last_of_run,
                   end_of_frame, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, out_alpha, last_of_run,
                   end_of_frame, output ready);
endinterface

`default_nettype wire

>>> rtl/core/cme_row_store.sv
`default_nettype none

module cme_row_store #(
   parameter int unsigned DEPTH = cme_pkg::MAX_WIDTH_DEF,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                     clock,
   input  wire cme_pkg::store_ctl_type   ctl,
   input  wire logic [AW-1:0]            addr,
   input  wire cme_pkg::prev_entry_type  prev_wdata,
   input  wire cme_pkg::older_entry_type older_wdata,
   output cme_pkg::prev_entry_type       prev_rdata,
   output cme_pkg::older_entry_type      older_rdata
);

   cme_pkg::prev_entry_type  prev_mem_ff  [DEPTH];
   cme_pkg::older_entry_type older_mem_ff [DEPTH];
   cme_pkg::prev_entry_type  prev_rd_ff;
   cme_pkg::older_entry_type older_rd_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_prev) begin
         prev_mem_ff[addr] <= prev_wdata;
      end
      if (ctl.wr_older) begin
         older_mem_ff[addr] <= older_wdata;
      end
      if (ctl.rd_en) begin
         prev_rd_ff  <= prev_mem_ff[addr];
         older_rd_ff <= older_mem_ff[addr];
      end
   end

   assign prev_rdata  = prev_rd_ff;
   assign older_rdata = older_rd_ff;

endmodule

`default_nettype wire

>>> rtl/core/cme_csr.sv
`default_nettype none

module cme_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [cme_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [cme_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [cme_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                   pready,
   output logic [cme_pkg::SIZE_W-1:0]             image_width,
   output logic [cme_pkg::SIZE_W-1:0]             image_height,
   output cme_pkg::tap_set_type                   taps
);

   logic [cme_pkg::SIZE_W-1:0]     width_ff;
   logic [cme_pkg::SIZE_W-1:0]     height_ff;
   logic [cme_pkg::CSR_DATA_W-1:0] taps_low_ff;
   logic [cme_pkg::CSR_DATA_W-1:0] taps_high_ff;
   logic [cme_pkg::TAP_W-1:0]      tap_last_ff;
   cme_pkg::csr_index_type         index;
   logic                           wr_en;

   assign index  = cme_pkg::csr_index_type'(paddr[cme_pkg::CSR_ADDR_W-1:3]);
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= cme_pkg::SIZE_W'(1);
         height_ff    <= cme_pkg::SIZE_W'(1);
         taps_low_ff  <= '0;
         taps_high_ff <= '0;
         tap_last_ff  <= '0;
      end else if (wr_en) begin
         unique case (index)
            cme_pkg::REG_IMAGE_WIDTH:  width_ff     <= pwdata[cme_pkg::SIZE_W-1:0];
            cme_pkg::REG_IMAGE_HEIGHT: height_ff    <= pwdata[cme_pkg::SIZE_W-1:0];
            cme_pkg::REG_TAPS_LOW:     taps_low_ff  <= pwdata;
            cme_pkg::REG_TAPS_HIGH:    taps_high_ff <= pwdata;
            cme_pkg::REG_TAP_LAST:     tap_last_ff  <= pwdata[cme_pkg::TAP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         cme_pkg::REG_IMAGE_WIDTH:  prdata = cme_pkg::CSR_DATA_W'(width_ff);
         cme_pkg::REG_IMAGE_HEIGHT: prdata = cme_pkg::CSR_DATA_W'(height_ff);
         cme_pkg::REG_TAPS_LOW:     prdata = taps_low_ff;
         cme_pkg::REG_TAPS_HIGH:    prdata = taps_high_ff;
         cme_pkg::REG_TAP_LAST:     prdata = cme_pkg::CSR_DATA_W'(tap_last_ff);
         default:                   prdata = '0;
      endcase
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         taps[i]     = taps_low_ff[16*i +: 16];
         taps[i + 4] = taps_high_ff[16*i +: 16];
      end
      taps[8] = tap_last_ff;
   end

   assign image_width  = width_ff;
   assign image_height = height_ff;

endmodule

`default_nettype wire

>>> rtl/core/cme_edge_unit.sv
`default_nettype none

module cme_edge_unit (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire cme_pkg::window_type  window,
   input  wire cme_pkg::tap_set_type taps,
   output logic                      done,
   output cme_pkg::rgb_out_type      result
);

   localparam int unsigned ACC_W  = 36;
   localparam int unsigned G_W    = 26;
   localparam int unsigned ABS_W  = 24;
   localparam int unsigned SQ_W   = 48;
   localparam int unsigned REM_W  = 26;
   localparam int unsigned PM_W   = 37;
   localparam int unsigned PC_W   = 30;
   localparam int unsigned V_W    = 40;

   cme_pkg::eu_state_type state_ff, state_in;

   logic [1:0]              ch_ff;
   logic [1:0]              r_ff;
   logic [1:0]              c_ff;
   logic signed [ACC_W-1:0] acc1_ff;
   logic signed [ACC_W-1:0] acc2_ff;
   logic [ABS_W-1:0]        abs1_ff;
   logic [ABS_W-1:0]        abs2_ff;
   logic [SQ_W-1:0]         sq_ff;
   logic [REM_W-1:0]        rem_ff;
   logic [ABS_W-1:0]        root_ff;
   logic [4:0]              step_ff;
   logic [PM_W-1:0]         pm_ff;
   logic signed [PC_W-1:0]  pc_ff;
   logic                    done_ff;
   cme_pkg::rgb_out_type    result_ff;

   logic signed [15:0]      pix;
   logic signed [15:0]      tap1;
   logic signed [15:0]      tap2;
   logic [3:0]              idx1;
   logic [3:0]              idx2;
   logic signed [G_W-1:0]   g1;
   logic signed [G_W-1:0]   g2;
   logic [REM_W+1:0]        rem_try;
   logic [REM_W+1:0]        trial;
   logic [cme_pkg::MIX_W-1:0] f;
   logic [cme_pkg::MIX_W-1:0] omf;
   logic signed [V_W-1:0]   v;
   logic signed [V_W-13:0]  vs;
   logic                    last_tap;
   logic                    last_ch;

   assign idx1 = 4'(3 * r_ff + c_ff);
   assign idx2 = 4'(3 * c_ff + r_ff);
   assign pix  = $signed(window[c_ff].rgb[r_ff][ch_ff]);
   assign tap1 = $signed(taps[idx1]);
   assign tap2 = $signed(taps[idx2]);

   assign g1 = G_W'((acc1_ff + ACC_W'(512)) >>> 10);
   assign g2 = G_W'((acc2_ff + ACC_W'(512)) >>> 10);

   assign rem_try = {rem_ff, sq_ff[SQ_W-1 -: 2]};
   assign trial   = {2'b00, root_ff, 2'b01};

   assign f   = (window[1].mix > cme_pkg::MIX_ONE) ? cme_pkg::MIX_ONE : window[1].mix;
   assign omf = cme_pkg::MIX_ONE - f;

   assign v  = $signed({3'b000, pm_ff}) + V_W'(pc_ff) + V_W'(2048);
   assign vs = v[V_W-1:12];

   assign last_tap = (r_ff == 2'd2) && (c_ff == 2'd2);
   assign last_ch  = (ch_ff == 2'(cme_pkg::NUM_CH - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cme_pkg::EU_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == cme_pkg::EU_SUM) && last_ch;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cme_pkg::EU_IDLE:   if (start) state_in = cme_pkg::EU_MAC;
         cme_pkg::EU_MAC:    if (last_tap) state_in = cme_pkg::EU_ROUND;
         cme_pkg::EU_ROUND:  state_in = cme_pkg::EU_SQUARE;
         cme_pkg::EU_SQUARE: state_in = cme_pkg::EU_SQRT;
         cme_pkg::EU_SQRT:   if (step_ff == 5'(ABS_W - 1)) state_in = cme_pkg::EU_MIX;
         cme_pkg::EU_MIX:    state_in = cme_pkg::EU_SUM;
         cme_pkg::EU_SUM:    state_in = last_ch ? cme_pkg::EU_IDLE : cme_pkg::EU_MAC;
         default:            state_in = cme_pkg::EU_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         cme_pkg::EU_IDLE: begin
            ch_ff   <= '0;
            r_ff    <= '0;
            c_ff    <= '0;
            acc1_ff <= '0;
            acc2_ff <= '0;
         end
         cme_pkg::EU_MAC: begin
            acc1_ff <= acc1_ff + ACC_W'(pix * tap1);
            acc2_ff <= acc2_ff + ACC_W'(pix * tap2);
            if (c_ff == 2'd2) begin
               c_ff <= '0;
               r_ff <= r_ff + 2'd1;
            end else begin
               c_ff <= c_ff + 2'd1;
            end
         end
         cme_pkg::EU_ROUND: begin
            abs1_ff <= ABS_W'(g1[G_W-1] ? -g1 : g1);
            abs2_ff <= ABS_W'(g2[G_W-1] ? -g2 : g2);
         end
         cme_pkg::EU_SQUARE: begin
            sq_ff   <= SQ_W'(abs1_ff * abs1_ff) + SQ_W'(abs2_ff * abs2_ff);
            rem_ff  <= '0;
            root_ff <= '0;
            step_ff <= '0;
         end
         cme_pkg::EU_SQRT: begin
            // two radicand bits per step, one root bit out
            sq_ff   <= {sq_ff[SQ_W-3:0], 2'b00};
            step_ff <= step_ff + 5'd1;
            if (rem_try >= trial) begin
               rem_ff  <= REM_W'(rem_try - trial);
               root_ff <= {root_ff[ABS_W-2:0], 1'b1};
            end else begin
               rem_ff  <= REM_W'(rem_try);
               root_ff <= {root_ff[ABS_W-2:0], 1'b0};
            end
         end
         cme_pkg::EU_MIX: begin
            pm_ff <= PM_W'(root_ff * f);
            pc_ff <= PC_W'($signed(window[1].rgb[1][ch_ff]) * $signed({1'b0, omf}));
         end
         cme_pkg::EU_SUM: begin
            if (vs < 0) begin
               result_ff[ch_ff] <= '0;
            end else if (vs > $signed((V_W-12)'(32767))) begin
               result_ff[ch_ff] <= '1;
            end else begin
               result_ff[ch_ff] <= vs[cme_pkg::OUT_W-1:0];
            end
            ch_ff   <= ch_ff + 2'd1;
            r_ff    <= '0;
            c_ff    <= '0;
            acc1_ff <= '0;
            acc2_ff <= '0;
         end
         default: ;
      endcase
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

`default_nettype wire

>>> rtl/core/conv3x3_edge_magnitude_mix_core.sv
`default_nettype none

// Channel   Dir  Handshake        Payload
// req       in   valid/ready      command, in_red/green/blue/alpha, mix_factor
// rsp       out  valid/ready      out_red/green/blue/alpha, last_of_run, end_of_frame
// csr       in   APB, 64-bit      image_width, image_height, taps_low/high_four, tap_last
//
// One request at a time. A request reads the row stores at most twice. Each
// result is made in order: start, then in the shared edge unit per channel
// 9 MAC steps, round, square, 24 square-root steps, mix and sum, then done
// and push. A pixel request gives at most two results; some requests give
// none. Reset is synchronous and needs no clearing pass; row stores hold
// garbage until written. A stalled rsp holds one result in the output
// register while the next is computed.

module conv3x3_edge_magnitude_mix_core #(
   parameter int unsigned MAX_WIDTH  = cme_pkg::MAX_WIDTH_DEF,
   parameter int unsigned MAX_HEIGHT = cme_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   cme_req_if.sink                             req,
   cme_rsp_if.source                           rsp,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [cme_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [cme_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [cme_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);

   localparam int unsigned XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int unsigned YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int unsigned EW = 14;

   logic [cme_pkg::SIZE_W-1:0] image_width;
   logic [cme_pkg::SIZE_W-1:0] image_height;
   cme_pkg::tap_set_type       taps;

   cme_pkg::core_state_type state_ff, state_in;

   logic [XW-1:0]               col_ff;
   logic [YW-1:0]               row_ff;
   logic [XW-1:0]               drain_ff;
   logic                        draining_ff;
   logic                        cmd_ff;
   cme_pkg::pixel_type [3:0]    cur_ff;
   logic [cme_pkg::MIX_W-1:0]   cur_mix_ff;
   cme_pkg::window_type         win_ff;
   logic                        first_phase_ff;
   logic                        pend_b_ff;
   logic                        last_ff;
   logic                        eof_ff;

   logic                        out_valid_ff;
   cme_pkg::rgb_out_type        out_rgb_ff;
   logic [cme_pkg::OUT_W-1:0]   out_alpha_ff;
   logic                        out_last_ff;
   logic                        out_eof_ff;

   logic [EW-1:0]               w_raw;
   logic [EW-1:0]               w_eff;
   logic [EW-1:0]               h_raw;
   logic [EW-1:0]               h_eff;
   logic [XW-1:0]               wm1;
   logic [YW-1:0]               hm1;
   logic [XW:0]                 drain_inc;
   logic [XW-1:0]               xn;
   logic                        is_drain;
   logic                        col_last;
   logic                        first_row;

   cme_pkg::store_ctl_type      ctl;
   logic [XW-1:0]               addr;
   cme_pkg::prev_entry_type     prev_wdata;
   cme_pkg::prev_entry_type     prev_rdata;
   cme_pkg::older_entry_type    older_rdata;
   cme_pkg::column_type         col;

   logic                        eu_start;
   logic                        eu_done;
   cme_pkg::rgb_out_type        eu_result;
   logic                        can_push;
   logic                        push;

   cme_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .image_width  (image_width),
      .image_height (image_height),
      .taps         (taps)
   );

   cme_row_store #(.DEPTH(MAX_WIDTH)) u_row_store (
      .clock       (clock),
      .ctl         (ctl),
      .addr        (addr),
      .prev_wdata  (prev_wdata),
      .older_wdata (prev_rdata.c[2:0]),
      .prev_rdata  (prev_rdata),
      .older_rdata (older_rdata)
   );

   cme_edge_unit u_edge_unit (
      .clock  (clock),
      .reset  (reset),
      .start  (eu_start),
      .window (win_ff),
      .taps   (taps),
      .done   (eu_done),
      .result (eu_result)
   );

   // effective frame size: zero acts as one, capped at the maximum
   assign w_raw = EW'(image_width);
   assign h_raw = EW'(image_height);
   assign w_eff = (w_raw == '0) ? EW'(1) : ((w_raw > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : w_raw);
   assign h_eff = (h_raw == '0) ? EW'(1)
                  : ((h_raw > EW'(MAX_HEIGHT)) ? EW'(MAX_HEIGHT) : h_raw);
   assign wm1   = XW'(w_eff - EW'(1));
   assign hm1   = YW'(h_eff - EW'(1));

   assign drain_inc = {1'b0, drain_ff} + (XW+1)'(1);
   assign xn        = (drain_inc <= {1'b0, wm1}) ? drain_inc[XW-1:0] : wm1;
   assign is_drain  = (cmd_ff == cme_pkg::CMD_DRAIN);
   assign col_last  = (col_ff >= wm1);
   assign first_row = is_drain ? (row_ff == '0) : (row_ff == YW'(1));

   assign prev_wdata.c   = cur_ff;
   assign prev_wdata.mix = cur_mix_ff;

   // column gathered from the row stores; the bottom row is the new pixel,
   // or the previous row again when flushing the last row
   always_comb begin
      col.rgb[0]    = first_row ? prev_rdata.c[2:0] : older_rdata;
      col.rgb[1]    = prev_rdata.c[2:0];
      col.rgb[2]    = is_drain ? prev_rdata.c[2:0] : cur_ff[2:0];
      col.alpha     = prev_rdata.c[3];
      col.mix       = prev_rdata.mix;
   end

   assign can_push = !out_valid_ff || rsp.ready;
   assign push     = (state_ff == cme_pkg::CS_EMIT_PUSH) && can_push;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cme_pkg::CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      addr     = is_drain ? xn : col_ff;
      eu_start = 1'b0;
      req.ready = 1'b0;
      unique case (state_ff)
         cme_pkg::CS_IDLE: begin
            req.ready = !reset;
            if (req.valid) state_in = cme_pkg::CS_DISPATCH;
         end
         cme_pkg::CS_DISPATCH: begin
            if (is_drain) begin
               if (!draining_ff) begin
                  state_in = cme_pkg::CS_IDLE;
               end else begin
                  ctl.rd_en = 1'b1;
                  if (drain_ff == '0) addr = '0;
                  state_in = cme_pkg::CS_GATHER;
               end
            end else if (draining_ff) begin
               state_in = cme_pkg::CS_IDLE;
            end else if (row_ff == '0) begin
               ctl.wr_prev = 1'b1;
               state_in    = cme_pkg::CS_FINISH;
            end else begin
               ctl.rd_en = 1'b1;
               state_in  = cme_pkg::CS_GATHER;
            end
         end
         cme_pkg::CS_GATHER: begin
            if (is_drain) begin
               if (first_phase_ff) begin
                  ctl.rd_en = 1'b1;
                  state_in  = cme_pkg::CS_GATHER;
               end else begin
                  state_in = cme_pkg::CS_EMIT_START;
               end
            end else begin
               ctl.wr_prev  = 1'b1;
               ctl.wr_older = 1'b1;
               state_in = ((col_ff != '0) || col_last) ? cme_pkg::CS_EMIT_START
                                                       : cme_pkg::CS_FINISH;
            end
         end
         cme_pkg::CS_EMIT_START: begin
            eu_start = 1'b1;
            state_in = cme_pkg::CS_EMIT_WAIT;
         end
         cme_pkg::CS_EMIT_WAIT: begin
            if (eu_done) state_in = cme_pkg::CS_EMIT_PUSH;
         end
         cme_pkg::CS_EMIT_PUSH: begin
            if (can_push) begin
               state_in = pend_b_ff ? cme_pkg::CS_EMIT_START : cme_pkg::CS_FINISH;
            end
         end
         cme_pkg::CS_FINISH: state_in = cme_pkg::CS_IDLE;
         default:            state_in = cme_pkg::CS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         drain_ff    <= '0;
         draining_ff <= 1'b0;
         win_ff      <= '0;
         pend_b_ff   <= 1'b0;
      end else begin
         unique case (state_ff)
            cme_pkg::CS_IDLE: begin
               if (req.valid) begin
                  cmd_ff     <= req.command;
                  cur_ff     <= {req.in_alpha, req.in_blue, req.in_green, req.in_red};
                  cur_mix_ff <= req.mix_factor;
               end
            end
            cme_pkg::CS_DISPATCH: begin
               first_phase_ff <= (drain_ff == '0);
            end
            cme_pkg::CS_GATHER: begin
               if (is_drain ? first_phase_ff : (col_ff == '0)) begin
                  win_ff <= {col, col, col};
               end else begin
                  win_ff <= {col, win_ff[2], win_ff[1]};
               end
               first_phase_ff <= 1'b0;
               if (is_drain) begin
                  last_ff   <= 1'b1;
                  eof_ff    <= (drain_ff >= wm1);
                  pend_b_ff <= 1'b0;
               end else begin
                  eof_ff <= 1'b0;
                  if (col_ff != '0) begin
                     last_ff   <= !col_last;
                     pend_b_ff <= col_last;
                  end else begin
                     last_ff   <= 1'b1;
                     pend_b_ff <= 1'b0;
                  end
               end
            end
            cme_pkg::CS_EMIT_PUSH: begin
               if (can_push && pend_b_ff) begin
                  // right border: replicate the last column
                  win_ff    <= {win_ff[2], win_ff[2], win_ff[1]};
                  last_ff   <= 1'b1;
                  pend_b_ff <= 1'b0;
               end
            end
            cme_pkg::CS_FINISH: begin
               if (is_drain) begin
                  if (drain_ff >= wm1) begin
                     drain_ff    <= '0;
                     col_ff      <= '0;
                     row_ff      <= '0;
                     draining_ff <= 1'b0;
                  end else begin
                     drain_ff <= drain_inc[XW-1:0];
                  end
               end else if (col_last) begin
                  col_ff <= '0;
                  if (row_ff >= hm1) begin
                     draining_ff <= 1'b1;
                  end else begin
                     row_ff <= row_ff + YW'(1);
                  end
               end else begin
                  col_ff <= col_ff + XW'(1);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (push) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         out_rgb_ff   <= eu_result;
         out_alpha_ff <= win_ff[1].alpha[cme_pkg::PIX_W-1] ? '0
                         : win_ff[1].alpha[cme_pkg::OUT_W-1:0];
         out_last_ff  <= last_ff;
         out_eof_ff   <= eof_ff;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.out_red      = out_rgb_ff[0];
   assign rsp.out_green    = out_rgb_ff[1];
   assign rsp.out_blue     = out_rgb_ff[2];
   assign rsp.out_alpha    = out_alpha_ff;
   assign rsp.last_of_run  = out_last_ff;
   assign rsp.end_of_frame = out_eof_ff;

endmodule

`default_nettype wire

>>> test/cme_edge_checker.sv
`timescale 1ns / 100ps

module cme_edge_checker
   import cme_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   cme_req_if                           req,
   cme_rsp_if                           rsp,
   input  wire logic                    psel,
   input  wire logic                    penable,
   input  wire logic                    pwrite,
   input  wire logic                    pready,
   input  wire logic [CSR_ADDR_W-1:0]   paddr,
   input  wire logic [CSR_DATA_W-1:0]   pwdata,
   output int unsigned                  fail_count,
   output int unsigned                  pending
);

   typedef struct {
      logic [OUT_W-1:0] red;
      logic [OUT_W-1:0] green;
      logic [OUT_W-1:0] blue;
      logic [OUT_W-1:0] alpha;
      logic             last_of_run;
      logic             end_of_frame;
   } edge_pixel_type;

   edge_pixel_type expected_pixels[$];

   logic [SIZE_W-1:0] width_reg, height_reg;
   logic [63:0]       taps_lo_reg, taps_hi_reg;
   logic [15:0]       tap8_reg;

   pixel_type [3:0]   row_above[MAX_WIDTH_DEF];
   logic [MIX_W-1:0]  row_above_mix[MAX_WIDTH_DEF];
   pixel_type [2:0]   row_older[MAX_WIDTH_DEF];
   window_type        win;
   int unsigned       col_cnt, row_cnt, drain_cnt;
   bit                draining;

   assign pending = expected_pixels.size();

   function automatic int unsigned eff_size(logic [SIZE_W-1:0] v, int unsigned max);
      if (v == 0) return 1;
      return (v > max) ? max : v;
   endfunction

   function automatic longint tap_weight(int unsigned i);
      if (i < 4) return longint'($signed(taps_lo_reg[16*i +: 16]));
      if (i < 8) return longint'($signed(taps_hi_reg[16*(i-4) +: 16]));
      return longint'($signed(tap8_reg));
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic [OUT_W-1:0] clamp15(longint v);
      if (v < 0) return '0;
      if (v > 32767) return 15'h7fff;
      return v[OUT_W-1:0];
   endfunction

   function automatic column_type gather_column(int unsigned x, bit first_row,
                                                pixel_type [2:0] bottom);
      column_type col;
      for (int ch = 0; ch < 3; ch++) begin
         col.rgb[0][ch] = first_row ? row_above[x][ch] : row_older[x][ch];
         col.rgb[1][ch] = row_above[x][ch];
         col.rgb[2][ch] = bottom[ch];
      end
      col.alpha = row_above[x][3];
      col.mix = row_above_mix[x];
      return col;
   endfunction

   function automatic void shift_column(column_type col);
      win[0] = win[1];
      win[1] = win[2];
      win[2] = col;
   endfunction

   function automatic void fill_window(column_type col);
      win[0] = col;
      win[1] = col;
      win[2] = col;
   endfunction

   function automatic void predict_edge_pixel(bit last, bit eof);
      edge_pixel_type e;
      longint g1, g2, f, mag, v, p;
      logic [OUT_W-1:0] o[3];
      f = (win[1].mix > MIX_ONE) ? 4096 : longint'(win[1].mix);
      for (int ch = 0; ch < 3; ch++) begin
         g1 = 0;
         g2 = 0;
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++) begin
               p = longint'($signed(win[c].rgb[r][ch]));
               g1 += p * tap_weight(3*r + c);
               g2 += p * tap_weight(3*c + r);
            end
         g1 = (g1 + 512) >>> 10;
         g2 = (g2 + 512) >>> 10;
         mag = longint'(int_sqrt(longint'(g1*g1) + longint'(g2*g2)));
         v = mag * f + longint'($signed(win[1].rgb[1][ch])) * (4096 - f);
         o[ch] = clamp15((v + 2048) >>> 12);
      end
      e.red = o[0];
      e.green = o[1];
      e.blue = o[2];
      e.alpha = clamp15(longint'($signed(win[1].alpha)));
      e.last_of_run = last;
      e.end_of_frame = eof;
      expected_pixels.push_back(e);
   endfunction

   function automatic void predict_request(command_type cmd, pixel_type [3:0] cur,
                                           logic [MIX_W-1:0] mix);
      int unsigned w, h, x, y, xn;
      bit first, eof;
      column_type col;
      w = eff_size(width_reg, MAX_WIDTH_DEF);
      h = eff_size(height_reg, MAX_HEIGHT_DEF);
      if (cmd == CMD_PIXEL) begin
         if (draining) return;
         x = col_cnt;
         y = row_cnt;
         if (y >= 1) begin
            col = gather_column(x, y == 1, cur[2:0]);
            if (x == 0) fill_window(col);
            else shift_column(col);
            if (x >= 1) predict_edge_pixel(!(x >= w - 1), 1'b0);
            if (x >= w - 1) begin
               if (x >= 1) shift_column(win[2]);
               predict_edge_pixel(1'b1, 1'b0);
            end
            row_older[x] = row_above[x][2:0];
         end
         row_above[x] = cur;
         row_above_mix[x] = mix;
         if (x >= w - 1) begin
            col_cnt = 0;
            if (y >= h - 1) draining = 1;
            else row_cnt = y + 1;
         end else begin
            col_cnt = x + 1;
         end
      end else begin
         if (!draining) return;
         x = drain_cnt;
         first = (row_cnt == 0);
         xn = (x + 1 <= w - 1) ? x + 1 : w - 1;
         eof = (x >= w - 1);
         if (x == 0) fill_window(gather_column(0, first, row_above[0][2:0]));
         shift_column(gather_column(xn, first, row_above[xn][2:0]));
         predict_edge_pixel(1'b1, eof);
         if (eof) begin
            drain_cnt = 0;
            col_cnt = 0;
            row_cnt = 0;
            draining = 0;
         end else begin
            drain_cnt = x + 1;
         end
      end
   endfunction

   always @(posedge clock) begin
      edge_pixel_type e;
      pixel_type [3:0] cur;
      if (reset) begin
         width_reg <= 1;
         height_reg <= 1;
         taps_lo_reg <= '0;
         taps_hi_reg <= '0;
         tap8_reg <= '0;
         win = '0;
         col_cnt = 0;
         row_cnt = 0;
         drain_cnt = 0;
         draining = 0;
         expected_pixels.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (csr_index_type'(paddr[5:3]))
               REG_IMAGE_WIDTH:  width_reg <= pwdata[SIZE_W-1:0];
               REG_IMAGE_HEIGHT: height_reg <= pwdata[SIZE_W-1:0];
               REG_TAPS_LOW:     taps_lo_reg <= pwdata;
               REG_TAPS_HIGH:    taps_hi_reg <= pwdata;
               REG_TAP_LAST:     tap8_reg <= pwdata[15:0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_pixels.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("[%0t] unexpected result %h %h %h %h", $realtime,
                           rsp.out_red, rsp.out_green, rsp.out_blue, rsp.out_alpha);
            end else begin
               e = expected_pixels.pop_front();
               if (rsp.out_red !== e.red || rsp.out_green !== e.green ||
                   rsp.out_blue !== e.blue || rsp.out_alpha !== e.alpha ||
                   rsp.last_of_run !== e.last_of_run ||
                   rsp.end_of_frame !== e.end_of_frame) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("[%0t] mismatch exp rgba %h %h %h %h last %b eof %b",
                              $realtime, e.red, e.green, e.blue, e.alpha, e.last_of_run,
                              e.end_of_frame, ", got %h %h %h %h last %b eof %b",
                              rsp.out_red, rsp.out_green, rsp.out_blue,
                              rsp.out_alpha, rsp.last_of_run, rsp.end_of_frame);
               end
            end
         end
         // config writes never coincide with requests, so old register values are fine here
         if (req.valid && req.ready) begin
            cur = {req.in_alpha, req.in_blue, req.in_green, req.in_red};
            predict_request(command_type'(req.command), cur, req.mix_factor);
         end
      end
   end

   initial fail_count = 0;

endmodule

>>> test/conv3x3_edge_magnitude_mix_core_tb.sv
`timescale 1ns / 100ps

module conv3x3_edge_magnitude_mix_core_tb;
   import cme_pkg::*;

   localparam int unsigned STALL_LIMIT = 8000;

   logic clock, reset;
   logic psel, penable, pwrite, pready;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata, prdata;

   int unsigned fail_count, pending, stall_cycles, pixel_reqs;
   bit req_idle_on, rsp_idle_on, rsp_hold;

   cme_req_if req_bus();
   cme_rsp_if rsp_bus();

   conv3x3_edge_magnitude_mix_core dut (
      .clock(clock), .reset(reset), .req(req_bus), .rsp(rsp_bus),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   cme_edge_checker checker_i (
      .clock(clock), .reset(reset), .req(req_bus), .rsp(rsp_bus),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("conv3x3_edge_magnitude_mix_core regression: fail");
            $finish;
         end
      end
   end

   // result side: random backpressure, plus one long hold-off on request
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold) begin
            rsp_bus.ready <= 1'b0;
            repeat (1500) @(posedge clock);
            rsp_hold = 0;
         end else begin
            rsp_bus.ready <= !rsp_idle_on || ($urandom_range(99) >= 30);
         end
      end
   end

   task automatic csr_write(input csr_index_type idx, input logic [63:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_W'(idx) << 3;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic send_req(input command_type cmd, input logic [15:0] r, g, b, a,
                           input logic [12:0] m);
      if (req_idle_on && $urandom_range(99) < 30) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 50);
      end
      req_bus.valid <= 1'b1;
      req_bus.command <= cmd;
      req_bus.in_red <= r;
      req_bus.in_green <= g;
      req_bus.in_blue <= b;
      req_bus.in_alpha <= a;
      req_bus.mix_factor <= m;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // the block can still be busy on a no-result request after the last result
   task automatic wait_quiet();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_pixel();
      case ($urandom_range(19))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [12:0] pick_mix();
      case ($urandom_range(9))
         0, 1: return 13'd0;
         2, 3: return MIX_ONE;
         4, 5: return 13'($urandom_range(8191, 4097));
         default: return 13'($urandom_range(4096));
      endcase
   endfunction

   task automatic run_frame(input logic [11:0] w_reg, h_reg, input logic [63:0] lo, hi,
                            input logic [15:0] t8, input bit noise, input bit directed);
      int unsigned w, h, k;
      logic [15:0] extremes[4];
      logic [12:0] mixes[4];
      extremes = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
      mixes = '{13'd0, MIX_ONE, 13'h1fff, 13'd2048};
      wait_quiet();
      csr_write(REG_IMAGE_WIDTH, 64'(w_reg));
      csr_write(REG_IMAGE_HEIGHT, 64'(h_reg));
      csr_write(REG_TAPS_LOW, lo);
      csr_write(REG_TAPS_HIGH, hi);
      csr_write(REG_TAP_LAST, 64'(t8));
      w = (w_reg == 0) ? 1 : (w_reg > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : w_reg);
      h = (h_reg == 0) ? 1 : (h_reg > MAX_HEIGHT_DEF ? MAX_HEIGHT_DEF : h_reg);
      for (int y = 0; y < h; y++)
         for (int x = 0; x < w; x++) begin
            // stray drain before the frame is complete is dropped by the block
            if (noise && $urandom_range(99) < 4)
               send_req(CMD_DRAIN, pick_pixel(), pick_pixel(), pick_pixel(), pick_pixel(),
                        pick_mix());
            k = x + y;
            if (directed)
               send_req(CMD_PIXEL, extremes[k % 4], extremes[(k+1) % 4],
                        extremes[(k+2) % 4], extremes[(k+3) % 4], mixes[k % 4]);
            else
               send_req(CMD_PIXEL, pick_pixel(), pick_pixel(), pick_pixel(), pick_pixel(),
                        pick_mix());
            pixel_reqs++;
         end
      for (int d = 0; d < w; d++) begin
         if (noise && $urandom_range(99) < 4)
            send_req(CMD_PIXEL, pick_pixel(), pick_pixel(), pick_pixel(), pick_pixel(),
                     pick_mix());
         send_req(CMD_DRAIN, pick_pixel(), pick_pixel(), pick_pixel(), pick_pixel(),
                  pick_mix());
         pixel_reqs++;
      end
   endtask

   initial begin
      int unsigned frames;
      reset <= 1'b1;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.command <= CMD_PIXEL;
      req_bus.in_red <= '0;
      req_bus.in_green <= '0;
      req_bus.in_blue <= '0;
      req_bus.in_alpha <= '0;
      req_bus.mix_factor <= '0;
      req_idle_on = 1;
      rsp_idle_on = 1;
      rsp_hold = 0;
      pixel_reqs = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: extreme taps and pixels, zero sizes, noise requests
      run_frame(12'd3, 12'd3, {4{16'h7fff}}, {4{16'h7fff}}, 16'h7fff, 1'b1, 1'b1);
      run_frame(12'd0, 12'd0, {4{16'h8000}}, {4{16'h8000}}, 16'h8000, 1'b0, 1'b1);
      run_frame(12'd2, 12'd2, {16'h0400, 16'h0000, 16'hfc00, 16'h0800},
                {16'h0000, 16'hf800, 16'h0400, 16'h0000}, 16'hfc00, 1'b1, 1'b1);

      frames = 0;
      while (pixel_reqs < 1440) begin
         if (frames == 6) rsp_hold = 1;
         if (frames == 10) begin
            req_idle_on = 0;
            rsp_idle_on = 0;
         end
         if (frames == 22) begin
            req_idle_on = 1;
            rsp_idle_on = 1;
         end
         run_frame(12'($urandom_range(12, 1)), 12'($urandom_range(6, 1)),
                   {$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom),
                   1'b1, 1'b0);
         frames++;
      end

      // a long single row and a tall single column, no idling
      req_idle_on = 0;
      rsp_idle_on = 0;
      run_frame(12'd40, 12'd1, {$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom),
                1'b0, 1'b0);
      run_frame(12'd1, 12'd20, {$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom),
                1'b0, 1'b0);

      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (fail_count == 0)
         $display("conv3x3_edge_magnitude_mix_core regression: pass");
      else
         $display("conv3x3_edge_magnitude_mix_core regression: fail");
      $finish;
   end

endmodule

>>> conv3x3_edge_magnitude_mix_core.f
rtl/core/cme_pkg.sv
rtl/core/cme_if.sv
rtl/core/cme_row_store.sv
rtl/core/cme_csr.sv
rtl/core/cme_edge_unit.sv
rtl/core/conv3x3_edge_magnitude_mix_core.sv
test/cme_edge_checker.sv
test/conv3x3_edge_magnitude_mix_core_tb.sv
